// File: rtl/core/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH           = 4;
    localparam int COUNT_W               = 16;
    localparam int REPL_MAX              = 8;

    localparam int COLOR_ON_LEN  = 5;
    localparam int COLOR_OFF_LEN = 4;
    localparam logic [2:0] COLOR_ON_LAST  = 3'(COLOR_ON_LEN - 1);
    localparam logic [2:0] COLOR_OFF_LAST = 3'(COLOR_OFF_LEN - 1);

    typedef enum logic [2:0] {
        REG_PATTERN_LENGTH     = 3'd0,
        REG_PATTERN_BYTES      = 3'd1,
        REG_REPLACEMENT_LENGTH = 3'd2,
        REG_REPLACEMENT_BYTES  = 3'd3,
        REG_HIGHLIGHT_ENABLE   = 3'd4
    } sfr_reg_index_t;

    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_REPL  = 2'd1,
        K_EMPTY = 2'd2
    } sfr_kind_t;

    typedef struct packed {
        logic [3:0]  pattern_length;
        logic [63:0] pattern_bytes;
        logic [3:0]  replacement_length;
        logic [63:0] replacement_bytes;
        logic        highlight_enable;
    } sfr_cfg_t;

    typedef struct packed {
        sfr_kind_t          kind;
        logic [7:0]         data;
        logic               last;
        logic [COUNT_W-1:0] count;
    } sfr_entry_t;

    function automatic logic [7:0] color_on_byte(input logic [2:0] i);
        logic [7:0] b;
        unique case (i)
            3'd0:    b = 8'h1B;
            3'd1:    b = 8'h5B;
            3'd2:    b = 8'h33;
            3'd3:    b = 8'h33;
            3'd4:    b = 8'h6D;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] color_off_byte(input logic [1:0] i);
        logic [7:0] b;
        unique case (i)
            2'd0:    b = 8'h1B;
            2'd1:    b = 8'h5B;
            2'd2:    b = 8'h30;
            default: b = 8'h6D;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/stream_find_replace_core.sv
// path: a beat is accepted, classified, queued, then loaded into the output register
// front steps per beat: accept, classify, push each released byte and any replacement or
// empty entry, stalling while the queue is full, then close; the next beat waits for it
// a replacement burst of up to 17 bytes drains at one byte a cycle while the output is not
// stalled, behind a 4-entry queue; reset: synchronous, active low; clears control state and
// sets registers to reset values, window contents stay undefined until written
`default_nettype none

module stream_find_replace_core #(
    parameter int MAX_PATTERN_BYTES = sfr_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // text_byte
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // out_byte, occurrence_count
    output logic        m_tuser,   // byte_present
    output logic        m_tlast
);
    import sfr_pkg::*;

    logic [3:0]  plen_reg;
    logic [63:0] pat_reg;
    logic [3:0]  rlen_reg;
    logic [63:0] repl_reg;
    logic        hl_reg;
    sfr_cfg_t    cfg;

    logic        push_valid, push_ready;
    sfr_entry_t  push_entry;
    logic        pop_valid, pop_ready;
    sfr_entry_t  pop_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= 4'd1;
            pat_reg  <= '0;
            rlen_reg <= '0;
            repl_reg <= '0;
            hl_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH:     plen_reg <= cfg_data[3:0];
                REG_PATTERN_BYTES:      pat_reg  <= cfg_data;
                REG_REPLACEMENT_LENGTH: rlen_reg <= cfg_data[3:0];
                REG_REPLACEMENT_BYTES:  repl_reg <= cfg_data;
                REG_HIGHLIGHT_ENABLE:   hl_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // replacement length clamped to eight bytes
    always_comb begin
        cfg.pattern_length     = plen_reg;
        cfg.pattern_bytes      = pat_reg;
        cfg.replacement_length = (int'(rlen_reg) > REPL_MAX) ? 4'(REPL_MAX) : rlen_reg;
        cfg.replacement_bytes  = repl_reg;
        cfg.highlight_enable   = hl_reg;
    end

    sfr_front #(
        .DEPTH (MAX_PATTERN_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    sfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/core/sfr_queue.sv
`default_nettype none

module sfr_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push_valid,
    input  sfr_pkg::sfr_entry_t push_entry,
    output logic                push_ready,
    output logic                pop_valid,
    output sfr_pkg::sfr_entry_t pop_entry,
    input  wire                 pop_ready
);
    import sfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    sfr_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              do_push, do_pop;

    assign push_ready = (level_reg != LVL_W'(QUEUE_DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            level_next = level_reg + LVL_W'(1);
        end else if (do_pop && !do_push) begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sfr_front.sv
`default_nettype none

module sfr_front #(
    parameter int DEPTH = sfr_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sfr_pkg::sfr_cfg_t   cfg,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,
    input  wire                 s_tlast,
    output logic                push_valid,
    output sfr_pkg::sfr_entry_t push_entry,
    input  wire                 push_ready
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_EMIT
    } front_state_t;

    front_state_t       state_reg, state_next;
    logic [7:0]         win_reg [DEPTH];
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               last_reg, last_next;
    logic               matched_reg, matched_next;
    logic [CNT_W-1:0]   sel_reg, sel_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               repl_pend_reg, repl_pend_next;
    logic               empty_pend_reg, empty_pend_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] step_total_reg, step_total_next;

    logic [CNT_W-1:0]   plen;
    logic               repl_empty;
    logic [CNT_W-1:0]   sel_c;
    logic               match_c;
    logic [CNT_W-1:0]   end_c;
    logic               accept;
    logic               shift_en;

    // effective pattern length: zero counts as one, clamped to the window
    always_comb begin
        if (cfg.pattern_length == 4'd0) begin
            plen = CNT_W'(1);
        end else if (int'(cfg.pattern_length) > DEPTH) begin
            plen = CNT_W'(DEPTH);
        end else begin
            plen = CNT_W'(cfg.pattern_length);
        end
    end

    assign repl_empty = (cfg.replacement_length == 4'd0) && !cfg.highlight_enable;

    // first shift whose tail is a prefix of the pattern
    always_comb begin
        int  len;
        logic agree;
        sel_c   = cnt_reg;
        match_c = 1'b0;
        for (int s = DEPTH - 1; s >= 0; s--) begin
            len   = int'(cnt_reg) - s;
            agree = 1'b1;
            for (int i = 0; i < DEPTH - s; i++) begin
                if ((i < len) && (win_reg[s + i] != cfg.pattern_bytes[8 * i +: 8])) begin
                    agree = 1'b0;
                end
            end
            if ((len > 0) && agree && (len <= int'(plen))) begin
                sel_c   = CNT_W'(s);
                match_c = (len == int'(plen));
            end
        end
    end

    assign end_c    = (last_reg && !match_c) ? cnt_reg : sel_c;
    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        matched_next    = matched_reg;
        sel_next        = sel_reg;
        end_next        = end_reg;
        ptr_next        = ptr_reg;
        repl_pend_next  = repl_pend_reg;
        empty_pend_next = empty_pend_reg;
        total_next      = total_reg;
        step_total_next = step_total_reg;
        shift_en        = 1'b0;
        push_valid      = 1'b0;
        push_entry      = '{kind: K_BYTE, data: win_reg[ptr_reg[IDX_W-1:0]],
                            last: 1'b0, count: step_total_reg};
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    last_next  = s_tlast;
                    state_next = F_CLASS;
                end
            end
            F_CLASS: begin
                sel_next        = sel_c;
                matched_next    = match_c;
                end_next        = end_c;
                ptr_next        = '0;
                repl_pend_next  = match_c && !repl_empty;
                empty_pend_next = last_reg && (end_c == '0) && !(match_c && !repl_empty);
                step_total_next = (match_c && (total_reg != '1)) ?
                                  total_reg + COUNT_W'(1) : total_reg;
                state_next      = F_EMIT;
            end
            F_EMIT: begin
                if (ptr_reg < end_reg) begin
                    push_valid      = 1'b1;
                    push_entry.last = last_reg && !repl_pend_reg &&
                                      ((ptr_reg + CNT_W'(1)) == end_reg);
                    if (push_ready) begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                end else if (repl_pend_reg) begin
                    push_valid      = 1'b1;
                    push_entry.kind = K_REPL;
                    push_entry.last = last_reg;
                    if (push_ready) begin
                        repl_pend_next = 1'b0;
                    end
                end else if (empty_pend_reg) begin
                    push_valid      = 1'b1;
                    push_entry.kind = K_EMPTY;
                    push_entry.data = 8'h00;
                    push_entry.last = 1'b1;
                    if (push_ready) begin
                        empty_pend_next = 1'b0;
                    end
                end else begin
                    total_next = last_reg ? '0 : step_total_reg;
                    cnt_next   = (matched_reg || last_reg) ? '0 : cnt_reg - sel_reg;
                    shift_en   = !(matched_reg || last_reg);
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            matched_reg    <= 1'b0;
            sel_reg        <= '0;
            end_reg        <= '0;
            ptr_reg        <= '0;
            repl_pend_reg  <= 1'b0;
            empty_pend_reg <= 1'b0;
            total_reg      <= '0;
            step_total_reg <= '0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            matched_reg    <= matched_next;
            sel_reg        <= sel_next;
            end_reg        <= end_next;
            ptr_reg        <= ptr_next;
            repl_pend_reg  <= repl_pend_next;
            empty_pend_reg <= empty_pend_next;
            total_reg      <= total_next;
            step_total_reg <= step_total_next;
        end
    end

    // window: append on accept, drop released bytes at the end of the beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg[cnt_reg[IDX_W-1:0]] <= s_tdata;
        end else if (shift_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                for (int k = 1; k < DEPTH - i; k++) begin
                    if (sel_reg == CNT_W'(k)) begin
                        win_reg[i] <= win_reg[i + k];
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_IDLE) |-> (int'(cnt_reg) < DEPTH))
        else $error("window full while waiting for a beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_CLASS) |=> (state_reg == F_EMIT))
        else $error("classification did not move to emission");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && !push_ready) |=> (push_valid && $stable(push_entry)))
        else $error("stalled queue entry changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_EMIT) |-> ((end_reg <= cnt_reg) && (sel_reg <= cnt_reg)))
        else $error("release range beyond window fill");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sfr_back.sv
`default_nettype none

module sfr_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sfr_pkg::sfr_cfg_t   cfg,
    input  wire                 pop_valid,
    input  sfr_pkg::sfr_entry_t pop_entry,
    output logic                pop_ready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ON,
        B_REP,
        B_OFF
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [2:0]         idx_reg, idx_next;
    logic               seq_last_reg, seq_last_next;
    logic [COUNT_W-1:0] seq_count_reg, seq_count_next;
    logic               valid_reg, valid_next;
    logic [7:0]         byte_reg, byte_next;
    logic               present_reg, present_next;
    logic               olast_reg, olast_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               out_load;
    logic               emit;
    logic               emit_final;
    logic [7:0]         emit_byte;

    assign out_load  = !valid_reg || m_tready;
    assign pop_ready = (state_reg == B_IDLE) && out_load;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        seq_last_next  = seq_last_reg;
        seq_count_next = seq_count_reg;
        valid_next     = valid_reg && !m_tready;
        byte_next      = byte_reg;
        present_next   = present_reg;
        olast_next     = olast_reg;
        count_next     = count_reg;
        emit           = 1'b0;
        emit_final     = 1'b0;
        emit_byte      = 8'h00;
        unique case (state_reg)
            B_IDLE: begin
                if (pop_valid && out_load) begin
                    if (pop_entry.kind == K_REPL) begin
                        seq_last_next  = pop_entry.last;
                        seq_count_next = pop_entry.count;
                        idx_next       = '0;
                        state_next     = cfg.highlight_enable ? B_ON : B_REP;
                    end else begin
                        valid_next   = 1'b1;
                        byte_next    = pop_entry.data;
                        present_next = (pop_entry.kind == K_BYTE);
                        olast_next   = pop_entry.last;
                        count_next   = pop_entry.count;
                    end
                end
            end
            B_ON: begin
                emit_byte = color_on_byte(idx_reg);
                if (out_load) begin
                    emit = 1'b1;
                    if (idx_reg == COLOR_ON_LAST) begin
                        idx_next   = '0;
                        state_next = (cfg.replacement_length != 4'd0) ? B_REP : B_OFF;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            B_REP: begin
                emit_byte = cfg.replacement_bytes[{idx_reg, 3'b000} +: 8];
                if (out_load) begin
                    emit = 1'b1;
                    if ((4'(idx_reg) + 4'd1) == cfg.replacement_length) begin
                        idx_next = '0;
                        if (cfg.highlight_enable) begin
                            state_next = B_OFF;
                        end else begin
                            emit_final = 1'b1;
                            state_next = B_IDLE;
                        end
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            B_OFF: begin
                emit_byte = color_off_byte(idx_reg[1:0]);
                if (out_load) begin
                    emit = 1'b1;
                    if (idx_reg == COLOR_OFF_LAST) begin
                        emit_final = 1'b1;
                        idx_next   = '0;
                        state_next = B_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
        if (emit) begin
            valid_next   = 1'b1;
            byte_next    = emit_byte;
            present_next = 1'b1;
            olast_next   = seq_last_reg && emit_final;
            count_next   = seq_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            idx_reg      <= '0;
            seq_last_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            seq_last_reg <= seq_last_next;
            valid_reg    <= valid_next;
        end
        seq_count_reg <= seq_count_next;
        byte_reg      <= byte_next;
        present_reg   <= present_next;
        olast_reg     <= olast_next;
        count_reg     <= count_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {count_reg, byte_reg};
    assign m_tuser  = present_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire
